// ===== src/slwbc_pkg.sv =====
package slwbc_pkg;

  // line geometry
  localparam int LINE_BYTES    = 8;
  localparam int OFF_BITS      = $clog2(LINE_BYTES);
  localparam int ADDR_BITS     = 8;
  localparam int LINE_NUM_BITS = ADDR_BITS - OFF_BITS;
  localparam int LINE_W        = 8 * LINE_BYTES;
  localparam int CNT_W         = 4;
  localparam int KIND_W        = 3;

  localparam logic [ADDR_BITS-1:0] ADDR_ALL  = '1;
  localparam logic [CNT_W-1:0]     LINE_CNT  = CNT_W'(LINE_BYTES);
  localparam logic [CNT_W-1:0]     MAX_FETCH = CNT_W'(8);

  // input opcodes
  localparam logic [1:0] OP_FETCH = 2'd0;
  localparam logic [1:0] OP_STORE = 2'd1;
  localparam logic [1:0] OP_DONE  = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_NONE   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DONE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REFILL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_WBACK  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DRD    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_DWR    = 3'd5;

  // outstanding miss
  typedef enum logic [1:0] {
    PEND_NONE     = 2'd0,
    PEND_REFILL   = 2'd1,
    PEND_WB_FILL  = 2'd2,
    PEND_WB_STORE = 2'd3
  } pend_t;

  // controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

  // bytes of a line starting at an offset, clipped to the count and line end
  function automatic logic [LINE_W-1:0] gather(input logic [LINE_W-1:0] line,
                                               input logic [OFF_BITS-1:0] off,
                                               input logic [CNT_W-1:0] cnt);
    logic [CNT_W:0]    room;
    logic [CNT_W:0]    lim;
    logic [CNT_W:0]    n;
    logic [LINE_W-1:0] sh;
    logic [LINE_W-1:0] res;
    room = (CNT_W+1)'(LINE_BYTES) - (CNT_W+1)'(off);
    lim  = ({1'b0, cnt} > {1'b0, MAX_FETCH}) ? {1'b0, MAX_FETCH} : {1'b0, cnt};
    n    = (lim < room) ? lim : room;
    sh   = line >> {off, 3'b000};
    res  = '0;
    for (int i = 0; i < LINE_BYTES; i++) begin
      if ((CNT_W+1)'(i) < n) begin
        res[8*i +: 8] = sh[8*i +: 8];
      end
    end
    return res;
  endfunction

endpackage

// ===== src/slwbc_ctrl.sv =====
module slwbc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output slwbc_pkg::cmd_t   cmd
);

  slwbc_pkg::state_t state;
  slwbc_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slwbc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      slwbc_pkg::ST_IDLE: if (start) state_next = slwbc_pkg::ST_RUN;
      slwbc_pkg::ST_RUN:  state_next = slwbc_pkg::ST_IDLE;
      default:            state_next = slwbc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy     = 1'b0;
    cmd.load = 1'b0;
    cmd.exec = 1'b0;
    unique case (state)
      slwbc_pkg::ST_IDLE: cmd.load = start;
      slwbc_pkg::ST_RUN: begin
        busy     = 1'b1;
        cmd.exec = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ===== src/slwbc_dp.sv =====
module slwbc_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  slwbc_pkg::cmd_t                        cmd,
  input  logic                                   cfg_we,
  input  logic                                   cfg_data,
  input  logic [1:0]                             opcode,
  input  logic [slwbc_pkg::ADDR_BITS-1:0]        address,
  input  logic [slwbc_pkg::CNT_W-1:0]            byte_count,
  input  logic [7:0]                             write_byte,
  input  logic [slwbc_pkg::LINE_W-1:0]           fill_line,
  output logic                                   done,
  output logic [slwbc_pkg::KIND_W-1:0]           kind,
  output logic [slwbc_pkg::ADDR_BITS-1:0]        mem_address,
  output logic [slwbc_pkg::CNT_W-1:0]            mem_count,
  output logic [slwbc_pkg::LINE_BYTES-1:0]       byte_mask,
  output logic [slwbc_pkg::LINE_W-1:0]           line_out,
  output logic [slwbc_pkg::LINE_W-1:0]           read_data,
  output logic [7:0]                             pass_data
);

  localparam int AB = slwbc_pkg::ADDR_BITS;
  localparam int OB = slwbc_pkg::OFF_BITS;
  localparam int LB = slwbc_pkg::LINE_BYTES;
  localparam int LW = slwbc_pkg::LINE_W;
  localparam int NB = slwbc_pkg::LINE_NUM_BITS;
  localparam int CW = slwbc_pkg::CNT_W;
  localparam int KW = slwbc_pkg::KIND_W;

  // captured item
  logic [1:0]    op_q;
  logic [AB-1:0] addr_q;
  logic [CW-1:0] cnt_q;
  logic [7:0]    wbyte_q;
  logic [LW-1:0] fill_q;

  // cache state
  logic              enable;
  logic [NB-1:0]     line_num, line_num_next;
  logic              line_valid, line_valid_next;
  logic [LB-1:0]     dirty, dirty_next;
  logic [LW-1:0]     line_bytes, line_bytes_next;
  slwbc_pkg::pend_t  pend_op, pend_op_next;
  logic [AB-1:0]     pend_addr, pend_addr_next;
  logic [CW-1:0]     pend_cnt, pend_cnt_next;
  logic [7:0]        pend_byte, pend_byte_next;

  // result values
  logic [KW-1:0]  kind_next;
  logic [AB-1:0]  mem_address_next;
  logic [CW-1:0]  mem_count_next;
  logic [LB-1:0]  byte_mask_next;
  logic [LW-1:0]  line_out_next;
  logic [LW-1:0]  read_data_next;
  logic [7:0]     pass_data_next;

  logic [NB-1:0]  a_line;
  logic [OB-1:0]  a_off;
  logic [NB-1:0]  p_line;
  logic [OB-1:0]  p_off;

  assign a_line = addr_q[AB-1:OB];
  assign a_off  = addr_q[OB-1:0];
  assign p_line = pend_addr[AB-1:OB];
  assign p_off  = pend_addr[OB-1:0];

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= opcode;
      addr_q  <= address;
      cnt_q   <= byte_count;
      wbyte_q <= write_byte;
      fill_q  <= fill_line;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
    end else if (cfg_we) begin
      enable <= cfg_data;
    end
  end

  // request / completion handling
  always_comb begin
    line_num_next    = line_num;
    line_valid_next  = line_valid;
    dirty_next       = dirty;
    line_bytes_next  = line_bytes;
    pend_op_next     = pend_op;
    pend_addr_next   = pend_addr;
    pend_cnt_next    = pend_cnt;
    pend_byte_next   = pend_byte;
    kind_next        = slwbc_pkg::KIND_NONE;
    mem_address_next = '0;
    mem_count_next   = '0;
    byte_mask_next   = '0;
    line_out_next    = '0;
    read_data_next   = '0;
    pass_data_next   = '0;

    if (op_q == slwbc_pkg::OP_DONE) begin
      case (pend_op)
        slwbc_pkg::PEND_REFILL: begin
          line_num_next   = p_line;
          line_bytes_next = fill_q;
          line_valid_next = 1'b1;
          dirty_next      = '0;
          kind_next       = slwbc_pkg::KIND_DONE;
          read_data_next  = slwbc_pkg::gather(fill_q, p_off, pend_cnt);
          pend_op_next    = slwbc_pkg::PEND_NONE;
        end
        slwbc_pkg::PEND_WB_FILL: begin
          dirty_next       = '0;
          kind_next        = slwbc_pkg::KIND_REFILL;
          mem_address_next = {p_line, {OB{1'b0}}};
          mem_count_next   = slwbc_pkg::LINE_CNT;
          pend_op_next     = slwbc_pkg::PEND_REFILL;
        end
        slwbc_pkg::PEND_WB_STORE: begin
          dirty_next = '0;
          if (pend_addr != slwbc_pkg::ADDR_ALL) begin
            if (p_line != line_num) begin
              line_num_next   = p_line;
              line_valid_next = 1'b0;
            end
            line_bytes_next[8*p_off +: 8] = pend_byte;
            dirty_next = LB'(1) << p_off;
          end
          kind_next    = slwbc_pkg::KIND_DONE;
          pend_op_next = slwbc_pkg::PEND_NONE;
        end
        default: ;
      endcase
    end else if (op_q == slwbc_pkg::OP_FETCH || op_q == slwbc_pkg::OP_STORE) begin
      if (!enable) begin
        // pass straight to memory
        mem_address_next = addr_q;
        if (op_q == slwbc_pkg::OP_FETCH) begin
          kind_next      = slwbc_pkg::KIND_DRD;
          mem_count_next = cnt_q;
        end else begin
          kind_next      = slwbc_pkg::KIND_DWR;
          mem_count_next = CW'(1);
          pass_data_next = wbyte_q;
        end
      end else if (pend_op == slwbc_pkg::PEND_NONE) begin
        if (op_q == slwbc_pkg::OP_FETCH) begin
          if (addr_q == slwbc_pkg::ADDR_ALL) begin
            // invalidate, dirty bytes kept
            line_valid_next = 1'b0;
            kind_next       = slwbc_pkg::KIND_DONE;
          end else if (a_line == line_num && line_valid) begin
            kind_next      = slwbc_pkg::KIND_DONE;
            read_data_next = slwbc_pkg::gather(line_bytes, a_off, cnt_q);
          end else begin
            pend_addr_next = addr_q;
            pend_cnt_next  = cnt_q;
            if (dirty != '0) begin
              kind_next        = slwbc_pkg::KIND_WBACK;
              mem_address_next = {line_num, {OB{1'b0}}};
              byte_mask_next   = dirty;
              line_out_next    = line_bytes;
              pend_op_next     = slwbc_pkg::PEND_WB_FILL;
            end else begin
              kind_next        = slwbc_pkg::KIND_REFILL;
              mem_address_next = {a_line, {OB{1'b0}}};
              mem_count_next   = slwbc_pkg::LINE_CNT;
              pend_op_next     = slwbc_pkg::PEND_REFILL;
            end
          end
        end else begin
          if (addr_q == slwbc_pkg::ADDR_ALL) begin
            // flush
            if (dirty != '0) begin
              kind_next        = slwbc_pkg::KIND_WBACK;
              mem_address_next = {line_num, {OB{1'b0}}};
              byte_mask_next   = dirty;
              line_out_next    = line_bytes;
              pend_addr_next   = addr_q;
              pend_op_next     = slwbc_pkg::PEND_WB_STORE;
            end else begin
              kind_next = slwbc_pkg::KIND_DONE;
            end
          end else if (a_line == line_num || dirty == '0) begin
            if (a_line != line_num) begin
              line_num_next   = a_line;
              line_valid_next = 1'b0;
            end
            line_bytes_next[8*a_off +: 8] = wbyte_q;
            dirty_next = dirty | (LB'(1) << a_off);
            kind_next  = slwbc_pkg::KIND_DONE;
          end else begin
            // store miss over dirty line: write back first
            kind_next        = slwbc_pkg::KIND_WBACK;
            mem_address_next = {line_num, {OB{1'b0}}};
            byte_mask_next   = dirty;
            line_out_next    = line_bytes;
            pend_addr_next   = addr_q;
            pend_byte_next   = wbyte_q;
            pend_op_next     = slwbc_pkg::PEND_WB_STORE;
          end
        end
      end
    end
  end

  // cache control state
  always_ff @(posedge clk) begin
    if (rst) begin
      line_num   <= '0;
      line_valid <= 1'b0;
      dirty      <= '0;
      pend_op    <= slwbc_pkg::PEND_NONE;
      pend_addr  <= '0;
      pend_cnt   <= '0;
      pend_byte  <= '0;
    end else if (cmd.exec) begin
      line_num   <= line_num_next;
      line_valid <= line_valid_next;
      dirty      <= dirty_next;
      pend_op    <= pend_op_next;
      pend_addr  <= pend_addr_next;
      pend_cnt   <= pend_cnt_next;
      pend_byte  <= pend_byte_next;
    end
  end

  // line data, no reset
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      line_bytes <= line_bytes_next;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.exec;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      kind        <= kind_next;
      mem_address <= mem_address_next;
      mem_count   <= mem_count_next;
      byte_mask   <= byte_mask_next;
      line_out    <= line_out_next;
      read_data   <= read_data_next;
      pass_data   <= pass_data_next;
    end
  end

endmodule

// ===== src/single_line_writeback_cache_core.sv =====
// One-line, eight-byte write-back cache with per-byte dirty marks. An item is
// taken when start is high and busy is low; busy then stays high while the line
// state is updated, and the result appears on the result ports with done high
// for exactly the following cycle. Every item gives one result (kind 0 when
// there is nothing to report), and the receiver cannot stall it.
// A new item can be started in the same cycle that done is high, but none is
// taken while busy is high for the update step of the controller's
// capture-then-update sequence. Requests to memory are reported as results;
// the matching completion is fed back in as an item with opcode 2.
// cache_enable is written on the cfg channel, accepted while busy is low.
module single_line_writeback_cache_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             opcode,
  input  logic [slwbc_pkg::ADDR_BITS-1:0]        address,
  input  logic [slwbc_pkg::CNT_W-1:0]            byte_count,
  input  logic [7:0]                             write_byte,
  input  logic [slwbc_pkg::LINE_W-1:0]           fill_line,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic                                   cfg_data,
  output logic                                   done,
  output logic [slwbc_pkg::KIND_W-1:0]           kind,
  output logic [slwbc_pkg::ADDR_BITS-1:0]        mem_address,
  output logic [slwbc_pkg::CNT_W-1:0]            mem_count,
  output logic [slwbc_pkg::LINE_BYTES-1:0]       byte_mask,
  output logic [slwbc_pkg::LINE_W-1:0]           line_out,
  output logic [slwbc_pkg::LINE_W-1:0]           read_data,
  output logic [7:0]                             pass_data
);

  slwbc_pkg::cmd_t cmd;
  logic            cfg_we;

  // config accepted whenever no item is in work
  assign cfg_ready = ~busy;
  assign cfg_we    = cfg_valid & cfg_ready;

  slwbc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  slwbc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .opcode      (opcode),
    .address     (address),
    .byte_count  (byte_count),
    .write_byte  (write_byte),
    .fill_line   (fill_line),
    .done        (done),
    .kind        (kind),
    .mem_address (mem_address),
    .mem_count   (mem_count),
    .byte_mask   (byte_mask),
    .line_out    (line_out),
    .read_data   (read_data),
    .pass_data   (pass_data)
  );

  // every result follows an update cycle
  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without an update cycle");

  // an accepted item always gets its update cycle
  a_accept_runs: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy ##1 done))
    else $error("accepted item produced no result");

  // a write-back always carries dirty bytes
  a_wback_dirty: assert property (@(posedge clk) disable iff (rst)
    (done && kind == slwbc_pkg::KIND_WBACK) |-> (byte_mask != '0))
    else $error("write-back with empty byte mask");

endmodule

// ===== verif/single_line_writeback_cache_core_tb.sv =====
module single_line_writeback_cache_core_tb;
  import slwbc_pkg::*;

  localparam logic [1:0] OP_RSVD = 2'd3;

  // one response of the cache
  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [ADDR_BITS-1:0]  maddr;
    logic [CNT_W-1:0]      mcnt;
    logic [LINE_BYTES-1:0] bmask;
    logic [LINE_W-1:0]     lout;
    logic [LINE_W-1:0]     rdata;
    logic [7:0]            pdata;
  } resp_t;

  // one row of the directed table: an item or an enable write
  typedef struct {
    bit                   is_cfg;
    logic [1:0]           op;
    logic [ADDR_BITS-1:0] addr;
    logic [CNT_W-1:0]     cnt;
    logic [7:0]           wb;
    logic [LINE_W-1:0]    fill;
    bit                   has_lit;
    resp_t                lit;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            opcode = OP_FETCH;
  logic [ADDR_BITS-1:0]  address = '0;
  logic [CNT_W-1:0]      byte_count = '0;
  logic [7:0]            write_byte = '0;
  logic [LINE_W-1:0]     fill_line = '0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_data = 1'b0;
  logic                  done;
  logic [KIND_W-1:0]     kind;
  logic [ADDR_BITS-1:0]  mem_address;
  logic [CNT_W-1:0]      mem_count;
  logic [LINE_BYTES-1:0] byte_mask;
  logic [LINE_W-1:0]     line_out;
  logic [LINE_W-1:0]     read_data;
  logic [7:0]            pass_data;

  // cache state as the predictor sees it
  logic                     c_en = 1'b0;
  logic [LINE_NUM_BITS-1:0] c_line = '0;
  logic                     c_valid = 1'b0;
  logic [LINE_BYTES-1:0]    c_dirty = '0;
  logic [LINE_W-1:0]        c_data = '0;
  pend_t                    c_pend = PEND_NONE;
  logic [ADDR_BITS-1:0]     c_paddr = '0;
  logic [CNT_W-1:0]         c_pcnt = '0;
  logic [7:0]               c_pbyte = '0;

  resp_t resp_q[$];
  row_t  plan[$];
  int    mismatches = 0;
  int    served = 0;
  int    calm_left = 0;

  single_line_writeback_cache_core uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .address(address),
    .byte_count(byte_count),
    .write_byte(write_byte),
    .fill_line(fill_line),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .done(done),
    .kind(kind),
    .mem_address(mem_address),
    .mem_count(mem_count),
    .byte_mask(byte_mask),
    .line_out(line_out),
    .read_data(read_data),
    .pass_data(pass_data)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  // bytes from the held line, clipped to the fetch limit and the line end
  function automatic logic [LINE_W-1:0] fetch_bytes(input logic [ADDR_BITS-1:0] a,
                                                    input logic [CNT_W-1:0] n);
    int                off;
    int                len;
    logic [LINE_W-1:0] v;
    off = a % LINE_BYTES;
    len = (n > MAX_FETCH) ? MAX_FETCH : n;
    if (len > LINE_BYTES - off) len = LINE_BYTES - off;
    v = '0;
    for (int i = 0; i < len; i++) v[8*i +: 8] = c_data[8*(off+i) +: 8];
    return v;
  endfunction

  // write one byte and mark it dirty, retargeting the line if needed
  function automatic void put_byte(input logic [ADDR_BITS-1:0] a, input logic [7:0] b);
    if (a[ADDR_BITS-1:OFF_BITS] != c_line) begin
      c_line  = a[ADDR_BITS-1:OFF_BITS];
      c_valid = 1'b0;
    end
    c_data[8*a[OFF_BITS-1:0] +: 8] = b;
    c_dirty[a[OFF_BITS-1:0]] = 1'b1;
  endfunction

  function automatic resp_t wback_resp();
    resp_t r;
    r       = '0;
    r.kind  = KIND_WBACK;
    r.maddr = {c_line, {OFF_BITS{1'b0}}};
    r.bmask = c_dirty;
    r.lout  = c_data;
    return r;
  endfunction

  function automatic resp_t refill_resp(input logic [ADDR_BITS-1:0] a);
    resp_t r;
    r       = '0;
    r.kind  = KIND_REFILL;
    r.maddr = {a[ADDR_BITS-1:OFF_BITS], {OFF_BITS{1'b0}}};
    r.mcnt  = LINE_CNT;
    return r;
  endfunction

  // next response of the cache for one item; updates the predicted state
  function automatic resp_t cache_predict(input logic [1:0] op,
                                          input logic [ADDR_BITS-1:0] addr,
                                          input logic [CNT_W-1:0] cnt,
                                          input logic [7:0] wb,
                                          input logic [LINE_W-1:0] fill);
    resp_t r;
    r = '0;
    if (op == OP_DONE) begin
      // memory completion finishes or advances whatever miss is outstanding
      case (c_pend)
        PEND_REFILL: begin
          c_line  = c_paddr[ADDR_BITS-1:OFF_BITS];
          c_data  = fill;
          c_valid = 1'b1;
          c_dirty = '0;
          r.kind  = KIND_DONE;
          r.rdata = fetch_bytes(c_paddr, c_pcnt);
          c_pend  = PEND_NONE;
        end
        PEND_WB_FILL: begin
          c_dirty = '0;
          r       = refill_resp(c_paddr);
          c_pend  = PEND_REFILL;
        end
        PEND_WB_STORE: begin
          c_dirty = '0;
          if (c_paddr != ADDR_ALL) put_byte(c_paddr, c_pbyte);
          r.kind = KIND_DONE;
          c_pend = PEND_NONE;
        end
        default: ;
      endcase
    end else if (op == OP_RSVD) begin
      r = '0;
    end else if (!c_en) begin
      // bypass straight to memory
      r.maddr = addr;
      if (op == OP_FETCH) begin
        r.kind = KIND_DRD;
        r.mcnt = cnt;
      end else begin
        r.kind  = KIND_DWR;
        r.mcnt  = 1;
        r.pdata = wb;
      end
    end else if (c_pend != PEND_NONE) begin
      r = '0;
    end else if (op == OP_FETCH) begin
      if (addr == ADDR_ALL) begin
        c_valid = 1'b0;
        r.kind  = KIND_DONE;
      end else if (addr[ADDR_BITS-1:OFF_BITS] == c_line && c_valid) begin
        r.kind  = KIND_DONE;
        r.rdata = fetch_bytes(addr, cnt);
      end else begin
        c_paddr = addr;
        c_pcnt  = cnt;
        if (c_dirty != 0) begin
          r      = wback_resp();
          c_pend = PEND_WB_FILL;
        end else begin
          r      = refill_resp(addr);
          c_pend = PEND_REFILL;
        end
      end
    end else begin
      // store, or flush on the all-ones address
      if (addr == ADDR_ALL) begin
        if (c_dirty != 0) begin
          r       = wback_resp();
          c_paddr = addr;
          c_pend  = PEND_WB_STORE;
        end else begin
          r.kind = KIND_DONE;
        end
      end else if (addr[ADDR_BITS-1:OFF_BITS] == c_line || c_dirty == 0) begin
        put_byte(addr, wb);
        r.kind = KIND_DONE;
      end else begin
        r       = wback_resp();
        c_paddr = addr;
        c_pbyte = wb;
        c_pend  = PEND_WB_STORE;
      end
    end
    return r;
  endfunction

  // ------------------------------------------------------------------ checker

  task automatic cmp_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t %s expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // every done cycle is matched against the oldest expected response
  always @(posedge clk) begin
    resp_t             want;
    logic [LINE_W-1:0] m;
    if (!rst && done) begin
      if (resp_q.size() == 0) begin
        $display("%0t unexpected response expected none actual kind %0d", $time, kind);
        mismatches++;
      end else begin
        want = resp_q.pop_front();
        // only dirty bytes of a write-back are defined
        for (int i = 0; i < LINE_BYTES; i++) m[8*i +: 8] = {8{want.bmask[i]}};
        cmp_field("kind", want.kind, kind);
        cmp_field("mem_address", want.maddr, mem_address);
        cmp_field("mem_count", want.mcnt, mem_count);
        cmp_field("byte_mask", want.bmask, byte_mask);
        cmp_field("line_out", want.lout & m, line_out & m);
        cmp_field("read_data", want.rdata, read_data);
        cmp_field("pass_data", want.pdata, pass_data);
      end
    end
  end

  // ------------------------------------------------------------------- driver

  // present one item after a random gap, predict it once it is taken
  task automatic send(input logic [1:0] op, input logic [ADDR_BITS-1:0] addr,
                      input logic [CNT_W-1:0] cnt, input logic [7:0] wb,
                      input logic [LINE_W-1:0] fill, input bit has_lit, input resp_t lit);
    int    gap;
    resp_t r;
    gap = (calm_left > 0) ? 0 : $urandom_range(0, 7);
    if (calm_left > 0) calm_left--;
    else if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(10, 30);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    opcode     <= op;
    address    <= addr;
    byte_count <= cnt;
    write_byte <= wb;
    fill_line  <= fill;
    do @(posedge clk); while (busy);
    r = cache_predict(op, addr, cnt, wb, fill);
    resp_q.push_back(has_lit ? lit : r);
    served++;
  endtask

  // stop issuing and let every outstanding response come back
  task automatic drain();
    start <= 1'b0;
    while (resp_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_enable(input logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    c_en = v;
  endtask

  // addresses clustered on a few lines so hits, conflicts and flushes occur
  function automatic logic [ADDR_BITS-1:0] pick_addr();
    int                       r;
    int                       sel;
    logic [LINE_NUM_BITS-1:0] ln;
    r = $urandom_range(0, 99);
    if (r < 6) return ADDR_ALL;
    if (r < 80) begin
      sel = $urandom_range(0, 3);
      ln  = (sel == 3) ? '1 : LINE_NUM_BITS'(sel);
      return {ln, OFF_BITS'($urandom_range(0, LINE_BYTES - 1))};
    end
    return ADDR_BITS'($urandom);
  endfunction

  // random item; an outstanding miss is mostly answered by a completion
  task automatic rand_item();
    int                   r;
    logic [1:0]           op;
    logic [ADDR_BITS-1:0] addr;
    logic [CNT_W-1:0]     cnt;
    logic [7:0]           wb;
    logic [LINE_W-1:0]    fill;
    r    = $urandom_range(0, 99);
    addr = pick_addr();
    cnt  = ($urandom_range(0, 9) == 0) ? CNT_W'($urandom_range(0, 15))
                                       : CNT_W'($urandom_range(1, 8));
    wb   = 8'($urandom);
    fill = {$urandom, $urandom};
    if (c_en && c_pend != PEND_NONE) op = (r < 85) ? OP_DONE : 2'($urandom_range(0, 3));
    else if (r < 45) op = OP_FETCH;
    else if (r < 88) op = OP_STORE;
    else if (r < 95) op = OP_DONE;
    else op = OP_RSVD;
    send(op, addr, cnt, wb, fill, 1'b0, '0);
  endtask

  // --------------------------------------------------------------- directed

  function automatic resp_t mk(input logic [KIND_W-1:0] k, input logic [ADDR_BITS-1:0] a,
                               input logic [CNT_W-1:0] c, input logic [7:0] d);
    resp_t r;
    r       = '0;
    r.kind  = k;
    r.maddr = a;
    r.mcnt  = c;
    r.pdata = d;
    return r;
  endfunction

  function automatic row_t row_item(input logic [1:0] op, input logic [ADDR_BITS-1:0] addr,
                                    input logic [CNT_W-1:0] cnt, input logic [7:0] wb,
                                    input logic [LINE_W-1:0] fill, input bit has_lit,
                                    input resp_t lit);
    row_t w;
    w.is_cfg  = 1'b0;
    w.op      = op;
    w.addr    = addr;
    w.cnt     = cnt;
    w.wb      = wb;
    w.fill    = fill;
    w.has_lit = has_lit;
    w.lit     = lit;
    return w;
  endfunction

  function automatic row_t row_cfg(input logic v);
    row_t w;
    w        = row_item(OP_FETCH, '0, '0, '0, '0, 1'b0, '0);
    w.is_cfg = 1'b1;
    w.addr   = {{(ADDR_BITS-1){1'b0}}, v};
    return w;
  endfunction

  // ---------------------------------------------------------------- sequence

  initial begin
    int plan_en[6];
    int plan_n[6];
    int target;
    plan_en = '{1, 0, 1, 1, 0, 1};
    plan_n  = '{140, 50, 140, 130, 50, 140};

    // bypass mode straight out of reset
    plan.push_back(row_item(OP_FETCH, 8'h00, 4'd8, 8'h00, '0, 1, mk(KIND_DRD, 8'h00, 4'd8, 8'h00)));
    plan.push_back(row_item(OP_STORE, 8'hFF, 4'd1, 8'hFF, '0, 1, mk(KIND_DWR, 8'hFF, 4'd1, 8'hFF)));
    plan.push_back(row_item(OP_RSVD, 8'h5A, 4'd3, 8'h11, '1, 1, '0));
    plan.push_back(row_item(OP_DONE, 8'h00, 4'd0, 8'h00, 64'h0123_4567_89AB_CDEF, 1, '0));
    plan.push_back(row_item(OP_FETCH, 8'hA5, 4'd0, 8'h00, '0, 1, mk(KIND_DRD, 8'hA5, 4'd0, 8'h00)));
    plan.push_back(row_item(OP_FETCH, 8'h3C, 4'd15, 8'h00, '0, 1, mk(KIND_DRD, 8'h3C, 4'd15, 8'h00)));
    plan.push_back(row_cfg(1'b1));
    // clean miss, ignored request while pending, refill, hits with clipping
    plan.push_back(row_item(OP_FETCH, 8'h13, 4'd4, 8'h00, '0, 1, mk(KIND_REFILL, 8'h10, 4'd8, 8'h00)));
    plan.push_back(row_item(OP_STORE, 8'h20, 4'd1, 8'h77, '0, 1, '0));
    plan.push_back(row_item(OP_DONE, 8'h00, 4'd0, 8'h00, 64'h8877_6655_4433_2211, 0, '0));
    plan.push_back(row_item(OP_FETCH, 8'h10, 4'd8, 8'h00, '0, 0, '0));
    plan.push_back(row_item(OP_FETCH, 8'h16, 4'd8, 8'h00, '0, 0, '0));
    plan.push_back(row_item(OP_FETCH, 8'h12, 4'd0, 8'h00, '0, 1, mk(KIND_DONE, 8'h00, 4'd0, 8'h00)));
    plan.push_back(row_item(OP_FETCH, 8'h11, 4'd15, 8'h00, '0, 0, '0));
    // store hits, then a conflicting store forces a write-back
    plan.push_back(row_item(OP_STORE, 8'h17, 4'd1, 8'hAA, '0, 1, mk(KIND_DONE, 8'h00, 4'd0, 8'h00)));
    plan.push_back(row_item(OP_STORE, 8'h10, 4'd1, 8'h00, '0, 1, mk(KIND_DONE, 8'h00, 4'd0, 8'h00)));
    plan.push_back(row_item(OP_STORE, 8'h40, 4'd1, 8'h55, '0, 0, '0));
    plan.push_back(row_item(OP_DONE, 8'h00, 4'd0, 8'h00, '0, 1, mk(KIND_DONE, 8'h00, 4'd0, 8'h00)));
    // flush with dirty bytes, then with none
    plan.push_back(row_item(OP_STORE, 8'hFF, 4'd1, 8'h00, '0, 0, '0));
    plan.push_back(row_item(OP_DONE, 8'h00, 4'd0, 8'h00, '0, 1, mk(KIND_DONE, 8'h00, 4'd0, 8'h00)));
    plan.push_back(row_item(OP_STORE, 8'hFF, 4'd1, 8'h00, '0, 1, mk(KIND_DONE, 8'h00, 4'd0, 8'h00)));
    // clean store retargets; dirty fetch miss writes back then refills
    plan.push_back(row_item(OP_STORE, 8'h80, 4'd1, 8'h3C, '0, 1, mk(KIND_DONE, 8'h00, 4'd0, 8'h00)));
    plan.push_back(row_item(OP_FETCH, 8'h81, 4'd3, 8'h00, '0, 0, '0));
    plan.push_back(row_item(OP_DONE, 8'h00, 4'd0, 8'h00, '0, 1, mk(KIND_REFILL, 8'h80, 4'd8, 8'h00)));
    plan.push_back(row_item(OP_DONE, 8'h00, 4'd0, 8'h00, '1, 0, '0));
    // invalidate, then the same line misses again
    plan.push_back(row_item(OP_FETCH, 8'hFF, 4'd8, 8'h00, '0, 1, mk(KIND_DONE, 8'h00, 4'd0, 8'h00)));
    plan.push_back(row_item(OP_FETCH, 8'h80, 4'd1, 8'h00, '0, 1, mk(KIND_REFILL, 8'h80, 4'd8, 8'h00)));
    plan.push_back(row_item(OP_DONE, 8'h00, 4'd0, 8'h00, {$urandom, $urandom}, 0, '0));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain();
        write_enable(plan[i].addr[0]);
      end else begin
        send(plan[i].op, plan[i].addr, plan[i].cnt, plan[i].wb, plan[i].fill,
             plan[i].has_lit, plan[i].lit);
      end
    end

    // random phases, switching the enable between them
    for (int p = 0; p < 6; p++) begin
      drain();
      write_enable(plan_en[p][0]);
      target = served + plan_n[p];
      while (served < target) rand_item();
    end

    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && resp_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
src/slwbc_pkg.sv
src/slwbc_ctrl.sv
src/slwbc_dp.sv
src/single_line_writeback_cache_core.sv
verif/single_line_writeback_cache_core_tb.sv
